>>> rtl/wrp_pkg.sv
// Package with the shared types and constants of the whiteboard report parser.
`default_nettype none
package wrp_pkg;

	localparam int MAX_REPORT_DEF  = 100;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [7:0] KIND_TOUCH   = 8'h05;
	localparam logic [7:0] KIND_STATUS  = 8'h02;
	localparam logic [7:0] KIND_BUTTONS = 8'h06;
	localparam logic [7:0] SUB_MAGIC    = 8'hc3;
	localparam logic [7:0] MINOR_IDLE   = 8'h00;
	localparam logic [7:0] MINOR_PENS   = 8'hd5;

	localparam logic [6:0] LEN_TOUCH_MIN   = 7'd8;
	localparam logic [6:0] LEN_STATUS_MIN  = 7'd6;
	localparam logic [6:0] LEN_BUTTONS_MIN = 7'd2;

	localparam logic [6:0] POS_KIND   = 7'd0;
	localparam logic [6:0] POS_ONE    = 7'd1;
	localparam logic [6:0] POS_TWO    = 7'd2;
	localparam logic [6:0] POS_X_LO   = 7'd4;
	localparam logic [6:0] POS_X_HI   = 7'd5;
	localparam logic [6:0] POS_Y_LO   = 7'd6;
	localparam logic [6:0] POS_Y_HI   = 7'd7;

	localparam int OUT_DATA_W = 48;

	typedef enum logic [3:0] {
		ST_TOUCH   = 4'd0,
		ST_PENS    = 4'd1,
		ST_BUTTONS = 4'd2,
		ST_IDLE    = 4'd3,
		ST_BADLEN  = 4'd4,
		ST_BADSUM  = 4'd5,
		ST_BADSUB  = 4'd6,
		ST_MINOR   = 4'd7,
		ST_KIND    = 4'd8
	} status_t;

	typedef struct packed {
		logic        too_long;
		logic [6:0]  len;
		logic [7:0]  kind;
		logic [7:0]  xsum;
		logic [7:0]  byte_one;
		logic [7:0]  byte_two;
		logic [7:0]  byte_five;
		logic [15:0] x;
		logic [15:0] y;
	} report_rec_t;

endpackage
`default_nettype wire

>>> rtl/whiteboard_report_parser_core.sv
// Top level of the whiteboard report parser.
// The block takes report bytes on the s_ stream, one request per byte, with s_tlast marking
// the last byte of a report; the first byte of each report is its kind.
// For every report it gives one verdict request on the m_ stream, and nothing for other bytes.
// A byte can be accepted in every clock cycle while the queue is not full, so throughput is one byte per cycle.
// After the last byte of a report is accepted, its summary is written into the queue and its verdict
// is then registered in the output stage and valid on m_tvalid, when the output stage is free.
// A front end collects the report fields and, at the last byte, writes a summary into a queue
// of QUEUE_DEPTH entries; the back end classifies the head entry into the output register.
// When the receiver stalls, the verdict holds on m_tdata and further summaries collect in the
// queue; s_tready falls only while the queue is full, which sets the only limit on input rate.
// The asynchronous reset clears the byte count, the gathered fields, the queue and the output
// valid, so the first byte after reset starts a new report.
// Reports longer than MAX_REPORT bytes are flagged as bad length.
`default_nettype none
module whiteboard_report_parser_core import wrp_pkg::*; #(
	parameter int MAX_REPORT  = MAX_REPORT_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [7:0]            s_tdata,  // report_byte
	input  wire logic                  s_tlast,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// status[3:0], touch_down[4], pos_x[20:5], pos_y[36:21], pen_bits[39:37],
	// colour_buttons[43:40], zero fill[47:44]
	output logic [OUT_DATA_W-1:0]      m_tdata
);

	logic        accept, push, pop, full, empty;
	report_rec_t push_rec, head_rec;

	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	wrp_front #(.MAX_REPORT(MAX_REPORT)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.rx_byte  (s_tdata),
		.rx_last  (s_tlast),
		.push     (push),
		.push_rec (push_rec)
	);

	wrp_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.head_rec (head_rec),
		.full     (full),
		.empty    (empty)
	);

	wrp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_rec  (head_rec),
		.empty     (empty),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule
`default_nettype wire

>>> rtl/wrp_front.sv
// Front end: takes report bytes, gathers the fields and queues a summary at the last byte.
`default_nettype none
module wrp_front import wrp_pkg::*; #(
	parameter int MAX_REPORT = MAX_REPORT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        rx_last,
	output logic             push,
	output report_rec_t      push_rec
);

	localparam logic [7:0] LEN_SAT = 8'(MAX_REPORT + 1);
	localparam logic [7:0] LEN_MAX = 8'(MAX_REPORT);

	logic [6:0]  count_q;
	logic [7:0]  kind_q, xsum_q, one_q, two_q, five_q;
	logic [15:0] x_q, y_q;
	logic [7:0]  kind_n, xsum_n, one_n, two_n, five_n;
	logic [15:0] x_n, y_n;
	logic [7:0]  len_raw, len;

	always_comb begin
		kind_n = kind_q;
		xsum_n = xsum_q ^ rx_byte;
		one_n  = one_q;
		two_n  = two_q;
		five_n = five_q;
		x_n    = x_q;
		y_n    = y_q;
		case (count_q)
			POS_KIND: begin
				kind_n = rx_byte;
				xsum_n = 8'd0;
			end
			POS_ONE:  one_n = rx_byte;
			POS_TWO:  two_n = rx_byte;
			POS_X_LO: x_n = {x_q[15:8], rx_byte};
			POS_X_HI: begin
				x_n    = {rx_byte, x_q[7:0]};
				five_n = rx_byte;
			end
			POS_Y_LO: y_n = {y_q[15:8], rx_byte};
			POS_Y_HI: y_n = {rx_byte, y_q[7:0]};
			default: ;
		endcase
		len_raw = {1'b0, count_q} + 8'd1;
		len     = (len_raw > LEN_SAT) ? LEN_SAT : len_raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			kind_q  <= '0;
			xsum_q  <= '0;
			one_q   <= '0;
			two_q   <= '0;
			five_q  <= '0;
			x_q     <= '0;
			y_q     <= '0;
		end else if (accept) begin
			count_q <= rx_last ? 7'd0 : len[6:0];
			kind_q  <= kind_n;
			xsum_q  <= xsum_n;
			one_q   <= one_n;
			two_q   <= two_n;
			five_q  <= five_n;
			x_q     <= x_n;
			y_q     <= y_n;
		end
	end

	always_comb begin
		push               = accept && rx_last;
		push_rec.too_long  = len > LEN_MAX;
		push_rec.len       = len[6:0];
		push_rec.kind      = kind_n;
		push_rec.xsum      = xsum_n;
		push_rec.byte_one  = one_n;
		push_rec.byte_two  = two_n;
		push_rec.byte_five = five_n;
		push_rec.x         = x_n;
		push_rec.y         = y_n;
	end

endmodule
`default_nettype wire

>>> rtl/wrp_fifo.sv
// Short queue of report summaries between the front and back ends.
`default_nettype none
module wrp_fifo import wrp_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  report_rec_t push_rec,
	input  wire logic   pop,
	output report_rec_t head_rec,
	output logic        full,
	output logic        empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	report_rec_t   mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full     = cnt_q == CNT_FULL;
	assign empty    = cnt_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_rec = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/wrp_back.sv
// Back end: turns a queued report summary into a verdict and holds it for the receiver.
`default_nettype none
module wrp_back import wrp_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  report_rec_t                head_rec,
	input  wire logic                  empty,
	output logic                       pop,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [OUT_DATA_W-1:0]      out_data
);

	status_t      st;
	logic         down;
	logic [15:0]  px, py;
	logic [2:0]   pens;
	logic [3:0]   cols;
	logic         vld_q;
	logic [OUT_DATA_W-1:0] data_q;

	always_comb begin
		st   = ST_KIND;
		down = 1'b0;
		px   = '0;
		py   = '0;
		pens = '0;
		cols = '0;
		if (head_rec.too_long) begin
			st = ST_BADLEN;
		end else if (head_rec.kind == KIND_TOUCH) begin
			if (head_rec.len < LEN_TOUCH_MIN) begin
				st = ST_BADLEN;
			end else begin
				st   = ST_TOUCH;
				down = head_rec.byte_one != 8'd0;
				px   = head_rec.x;
				py   = head_rec.y;
			end
		end else if (head_rec.kind == KIND_STATUS) begin
			if (head_rec.xsum != 8'd0) begin
				st = ST_BADSUM;
			end else if (head_rec.len < LEN_STATUS_MIN) begin
				st = ST_BADLEN;
			end else if (head_rec.byte_one != SUB_MAGIC) begin
				st = ST_BADSUB;
			end else if (head_rec.byte_two == MINOR_IDLE) begin
				st = ST_IDLE;
			end else if (head_rec.byte_two == MINOR_PENS) begin
				st   = ST_PENS;
				pens = head_rec.byte_five[2:0];
			end else begin
				st = ST_MINOR;
			end
		end else if (head_rec.kind == KIND_BUTTONS) begin
			if (head_rec.len < LEN_BUTTONS_MIN) begin
				st = ST_BADLEN;
			end else begin
				st   = ST_BUTTONS;
				cols = head_rec.byte_one[4:1];
			end
		end
	end

	assign pop = !empty && (!vld_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (!vld_q || out_ready) begin
			vld_q <= !empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= {4'd0, cols, pens, py, px, down, st};
		end
	end

	assign out_valid = vld_q;
	assign out_data  = data_q;

endmodule
`default_nettype wire

>>> dv/tb.sv
// Testbench for the whiteboard report parser core: directed and random reports.
`timescale 1ns / 100ps
module tb;
	import wrp_pkg::*;

	typedef struct packed {
		logic [3:0]  zero_fill;
		logic [3:0]  cols;
		logic [2:0]  pens;
		logic [15:0] pos_y;
		logic [15:0] pos_x;
		logic        touch;
		status_t     status;
	} verdict_t;

	typedef struct packed {
		logic [7:0]  len;
		logic [63:0] head;
		logic [7:0]  fill;
		logic        typed;
		verdict_t    want;
	} report_row_t;

	localparam int N_DIR = 24;

	logic                  clk;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata  = 8'h00;
	logic                  s_tlast  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	logic [6:0]  rpt_len  = '0;
	logic [7:0]  rpt_kind = '0;
	logic [7:0]  rpt_xsum = '0;
	logic [7:0]  rpt_b1   = '0;
	logic [7:0]  rpt_b2   = '0;
	logic [7:0]  rpt_b5   = '0;
	logic [15:0] rpt_x    = '0;
	logic [15:0] rpt_y    = '0;

	verdict_t    verdict_q[$];
	report_row_t dir_rows[N_DIR];
	int          n_bad   = 0;
	bit          tx_calm = 1'b0;
	bit          rx_calm = 1'b0;

	whiteboard_report_parser_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("whiteboard_report_parser_core: mismatch");
		$finish;
	end

	function automatic verdict_t mk_verdict(status_t st, logic down = 1'b0,
			logic [15:0] x = '0, logic [15:0] y = '0, logic [2:0] pens = '0,
			logic [3:0] cols = '0);
		verdict_t v;
		v        = '0;
		v.status = st;
		v.touch  = down;
		v.pos_x  = x;
		v.pos_y  = y;
		v.pens   = pens;
		v.cols   = cols;
		return v;
	endfunction

	task automatic flag_bad(input string what, input int unsigned got, input int unsigned want);
		n_bad++;
		if (n_bad <= 200)
			$display("%0t ns %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	// Takes one accepted byte into the gathered report fields and classifies the report
	// when the byte is the last one.
	task automatic parse_byte(input logic [7:0] b, input logic last, output bit done,
			output verdict_t v);
		logic [6:0] len;
		status_t    st;
		v    = '0;
		done = 1'b0;
		if (rpt_len == POS_KIND) begin
			rpt_kind = b;
			rpt_xsum = '0;
		end else begin
			rpt_xsum = rpt_xsum ^ b;
			case (rpt_len)
				POS_ONE:  rpt_b1 = b;
				POS_TWO:  rpt_b2 = b;
				POS_X_LO: rpt_x[7:0] = b;
				POS_X_HI: begin
					rpt_x[15:8] = b;
					rpt_b5      = b;
				end
				POS_Y_LO: rpt_y[7:0] = b;
				POS_Y_HI: rpt_y[15:8] = b;
				default:  ;
			endcase
		end
		if (rpt_len > 7'(MAX_REPORT_DEF))
			len = 7'(MAX_REPORT_DEF + 1);
		else
			len = rpt_len + 7'd1;
		rpt_len = len;
		if (!last)
			return;
		rpt_len = '0;
		done    = 1'b1;
		if (len > 7'(MAX_REPORT_DEF)) begin
			st = ST_BADLEN;
		end else if (rpt_kind == KIND_TOUCH) begin
			if (len < LEN_TOUCH_MIN) begin
				st = ST_BADLEN;
			end else begin
				st      = ST_TOUCH;
				v.touch = (rpt_b1 != 8'h00);
				v.pos_x = rpt_x;
				v.pos_y = rpt_y;
			end
		end else if (rpt_kind == KIND_STATUS) begin
			if (rpt_xsum != 8'h00)
				st = ST_BADSUM;
			else if (len < LEN_STATUS_MIN)
				st = ST_BADLEN;
			else if (rpt_b1 != SUB_MAGIC)
				st = ST_BADSUB;
			else if (rpt_b2 == MINOR_IDLE)
				st = ST_IDLE;
			else if (rpt_b2 == MINOR_PENS) begin
				st     = ST_PENS;
				v.pens = rpt_b5[2:0];
			end else
				st = ST_MINOR;
		end else if (rpt_kind == KIND_BUTTONS) begin
			if (len < LEN_BUTTONS_MIN) begin
				st = ST_BADLEN;
			end else begin
				st     = ST_BUTTONS;
				v.cols = rpt_b1[4:1];
			end
		end else begin
			st = ST_KIND;
		end
		v.status = st;
	endtask

	task automatic send_report(input logic [7:0] body[$], input logic typed, input verdict_t want);
		int       gap;
		bit       done;
		verdict_t v;
		foreach (body[i]) begin
			if ($urandom_range(0, 31) == 0)
				tx_calm = !tx_calm;
			gap = tx_calm ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= body[i];
			s_tlast  <= (i == body.size() - 1);
			do @(posedge clk); while (!s_tready);
			parse_byte(body[i], i == body.size() - 1, done, v);
			if (done)
				verdict_q.push_back(typed ? want : v);
		end
	endtask

	initial begin
		logic [7:0] body[$];
		logic [7:0] kind;
		logic [7:0] xs;
		int         pick;
		int         rlen;
		int         n_sent;
		n_sent = 0;
		// The first byte of a report sits in the lowest byte of the head column.
		dir_rows = '{
			'{8'd8,   64'h5678_1234_0000_0105, 8'h00, 1'b1,
				mk_verdict(ST_TOUCH, 1'b1, 16'h1234, 16'h5678)},
			'{8'd8,   64'hffff_ffff_ffff_ff05, 8'h00, 1'b1,
				mk_verdict(ST_TOUCH, 1'b1, 16'hffff, 16'hffff)},
			'{8'd8,   64'h0000_0000_0000_0005, 8'h00, 1'b1, mk_verdict(ST_TOUCH)},
			'{8'd7,   64'h0011_2233_4455_6605, 8'h00, 1'b1, mk_verdict(ST_BADLEN)},
			'{8'd20,  64'h8070_6050_4030_2005, 8'ha5, 1'b0, mk_verdict(ST_TOUCH)},
			'{8'd6,   64'h0000_0100_0000_c302, 8'h00, 1'b1, mk_verdict(ST_BADSUM)},
			'{8'd1,   64'h0000_0000_0000_0002, 8'h00, 1'b1, mk_verdict(ST_BADLEN)},
			'{8'd5,   64'h0000_0000_00c3_c302, 8'h00, 1'b1, mk_verdict(ST_BADLEN)},
			'{8'd6,   64'h0000_1100_0000_1102, 8'h00, 1'b1, mk_verdict(ST_BADSUB)},
			'{8'd6,   64'h0000_c300_0000_c302, 8'h00, 1'b1, mk_verdict(ST_IDLE)},
			'{8'd6,   64'h0000_1600_00d5_c302, 8'h00, 1'b0, mk_verdict(ST_PENS)},
			'{8'd7,   64'h0011_0700_00d5_c302, 8'h00, 1'b0, mk_verdict(ST_PENS)},
			'{8'd6,   64'h0000_8700_0044_c302, 8'h00, 1'b1, mk_verdict(ST_MINOR)},
			'{8'd100, 64'h0000_c300_0000_c302, 8'h00, 1'b0, mk_verdict(ST_IDLE)},
			'{8'd1,   64'h0000_0000_0000_0006, 8'h00, 1'b1, mk_verdict(ST_BADLEN)},
			'{8'd2,   64'h0000_0000_0000_1e06, 8'h00, 1'b0, mk_verdict(ST_BUTTONS)},
			'{8'd3,   64'h0000_0000_00ff_e106, 8'h00, 1'b0, mk_verdict(ST_BUTTONS)},
			'{8'd1,   64'h0000_0000_0000_0000, 8'h00, 1'b1, mk_verdict(ST_KIND)},
			'{8'd3,   64'h0000_0000_00ff_ffff, 8'h00, 1'b1, mk_verdict(ST_KIND)},
			'{8'd101, 64'h5678_1234_0000_0105, 8'h5a, 1'b1, mk_verdict(ST_BADLEN)},
			'{8'd9,   64'h0000_0000_0000_0007, 8'h00, 1'b1, mk_verdict(ST_KIND)},
			'{8'd130, 64'h0000_0000_0000_0002, 8'hff, 1'b1, mk_verdict(ST_BADLEN)},
			'{8'd12,  64'hffff_ffff_ffff_ff05, 8'h3c, 1'b0, mk_verdict(ST_TOUCH)},
			'{8'd8,   64'h0102_0304_0506_0705, 8'h00, 1'b0, mk_verdict(ST_TOUCH)}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[r]) begin
			body.delete();
			for (int i = 0; i < dir_rows[r].len; i++)
				body.push_back(i < 8 ? dir_rows[r].head[8*i +: 8] : dir_rows[r].fill);
			send_report(body, dir_rows[r].typed, dir_rows[r].want);
			n_sent += int'(dir_rows[r].len);
		end

		while (n_sent < 600) begin
			pick = $urandom_range(0, 99);
			body.delete();
			if (pick < 30) begin
				kind = KIND_TOUCH;
				rlen = (pick < 4) ? $urandom_range(1, 7) : $urandom_range(8, 12);
			end else if (pick < 65) begin
				kind = KIND_STATUS;
				rlen = (pick < 40) ? $urandom_range(1, 5) : $urandom_range(6, 10);
			end else if (pick < 85) begin
				kind = KIND_BUTTONS;
				rlen = (pick < 68) ? 1 : $urandom_range(2, 4);
			end else if (pick < 97) begin
				do kind = 8'($urandom_range(0, 255));
				while (kind inside {KIND_TOUCH, KIND_STATUS, KIND_BUTTONS});
				rlen = $urandom_range(1, 6);
			end else begin
				case ($urandom_range(0, 3))
					0:       kind = KIND_TOUCH;
					1:       kind = KIND_STATUS;
					2:       kind = KIND_BUTTONS;
					default: kind = 8'($urandom_range(0, 255));
				endcase
				rlen = $urandom_range(98, 130);
			end
			body.push_back(kind);
			for (int i = 1; i < rlen; i++)
				body.push_back(8'($urandom_range(0, 255)));
			// Most status reports carry the sub code and a closing byte that zeroes the XOR.
			if (kind == KIND_STATUS && rlen > 1) begin
				if (rlen > 2 && $urandom_range(0, 9) != 0)
					body[1] = SUB_MAGIC;
				if (rlen > 3) begin
					case ($urandom_range(0, 2))
						0:       body[2] = MINOR_IDLE;
						1:       body[2] = MINOR_PENS;
						default: ;
					endcase
				end
				if ($urandom_range(0, 7) != 0) begin
					xs = 8'h00;
					for (int i = 1; i < rlen - 1; i++)
						xs = xs ^ body[i];
					body[rlen-1] = xs;
				end
			end
			send_report(body, 1'b0, '0);
			n_sent += rlen;
		end

		s_tvalid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (n_bad == 0)
			$display("whiteboard_report_parser_core: match");
		else
			$display("whiteboard_report_parser_core: mismatch");
		$finish;
	end

	initial begin
		verdict_t got_v;
		verdict_t want_v;
		int       gap;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 15) == 0)
				rx_calm = !rx_calm;
			gap = rx_calm ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			got_v = verdict_t'(m_tdata);
			if (verdict_q.size() == 0) begin
				flag_bad("verdict with none expected", got_v.status, 0);
			end else begin
				want_v = verdict_q.pop_front();
				if (got_v.status !== want_v.status)
					flag_bad("status", got_v.status, want_v.status);
				if (got_v.touch !== want_v.touch)
					flag_bad("touch_down", got_v.touch, want_v.touch);
				if (got_v.pos_x !== want_v.pos_x)
					flag_bad("pos_x", got_v.pos_x, want_v.pos_x);
				if (got_v.pos_y !== want_v.pos_y)
					flag_bad("pos_y", got_v.pos_y, want_v.pos_y);
				if (got_v.pens !== want_v.pens)
					flag_bad("pen_bits", got_v.pens, want_v.pens);
				if (got_v.cols !== want_v.cols)
					flag_bad("colour_buttons", got_v.cols, want_v.cols);
				if (got_v.zero_fill !== 4'h0)
					flag_bad("zero fill", got_v.zero_fill, 0);
			end
		end
	end

endmodule
